FILE: src/mp2rgb_pkg.sv
// Shared types, register map and divider step for the packed pixel to RGB888 converter.
package mp2rgb_pkg;

  // Register indexes, taken from paddr[4:2].
  localparam logic [2:0] RegBytesPerPixel = 3'd0;
  localparam logic [2:0] RegMsbFirst      = 3'd1;
  localparam logic [2:0] RegRedMask       = 3'd2;
  localparam logic [2:0] RegGreenMask     = 3'd3;
  localparam logic [2:0] RegBlueMask      = 3'd4;

  // Register reset values.
  localparam logic [2:0]  BytesPerPixelRst = 3'd4;
  localparam logic        MsbFirstRst      = 1'b0;
  localparam logic [31:0] RedMaskRst       = 32'h00FF_0000;
  localparam logic [31:0] GreenMaskRst     = 32'h0000_FF00;
  localparam logic [31:0] BlueMaskRst      = 32'h0000_00FF;

  localparam int unsigned NumChan = 3;

  // Numerator v*510+m stays below 511*2^32, so 41 bits hold it.
  typedef logic [40:0] num_t;
  // Divisor 2*m.
  typedef logic [32:0] div_t;

  typedef struct packed {
    num_t rem;
    logic qbit;
  } div_res_t;

  // One restoring-division step for quotient bit k.
  function automatic div_res_t div_step(num_t r, div_t d, logic [2:0] k);
    num_t     sh;
    div_res_t res;
    sh = num_t'(d) << k;
    if (r >= sh) begin
      res.rem  = r - sh;
      res.qbit = 1'b1;
    end else begin
      res.rem  = r;
      res.qbit = 1'b0;
    end
    return res;
  endfunction

endpackage

FILE: src/mp2rgb_pix_if.sv
// Handshake channel that carries one packed pixel word.
interface mp2rgb_pix_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_bytes;

  modport source (output valid, output pixel_bytes, input ready);
  modport sink (input valid, input pixel_bytes, output ready);
endinterface

FILE: src/mp2rgb_rgb_if.sv
// Handshake channel that carries one 8-bit red, green and blue result.
interface mp2rgb_rgb_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

FILE: src/masked_pixel_to_rgb888_top.sv
// Packed pixel to RGB888 converter: byte assembly, channel masking and rounded scaling.
//
// Usage: pix_i takes one packed pixel word (pixel_bytes, first memory byte in
// bits 7:0) per valid/ready handshake; rgb_o delivers one red/green/blue word
// for every accepted pixel, in order. Byte count, byte order and the three
// channel masks are written through the APB port (register i at byte 4*i)
// while the block is idle; pready is always high and reads return the value.
// A new word is taken every cycle when the output is not stalled. The block is
// a six-stage pipeline: byte assembly and masking, numerator build, then four
// stages of a restoring divider that each resolve two quotient bits of
// (v*510+m)/(2m), the last of which is the output register.
// When the receiver holds ready low, each stage keeps its word until the stage
// after it frees, so pix_i.ready drops only once the pipeline is full; no word
// is dropped or repeated. Reset empties the pipeline and returns the registers
// to bytes_per_pixel 4, lsb first, and masks 0xFF0000, 0x00FF00 and 0x0000FF.
module masked_pixel_to_rgb888_top
  import mp2rgb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  mp2rgb_pix_if.sink        pix_i,
  mp2rgb_rgb_if.source      rgb_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned NumStages = 6;
  localparam int unsigned LastStage = NumStages - 1;

  // Configuration registers.
  logic [2:0]  bpp_q;
  logic        msb_first_q;
  logic [31:0] red_mask_q, green_mask_q, blue_mask_q;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q        <= BytesPerPixelRst;
      msb_first_q  <= MsbFirstRst;
      red_mask_q   <= RedMaskRst;
      green_mask_q <= GreenMaskRst;
      blue_mask_q  <= BlueMaskRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegBytesPerPixel: bpp_q        <= pwdata[2:0];
        RegMsbFirst:      msb_first_q  <= pwdata[0];
        RegRedMask:       red_mask_q   <= pwdata;
        RegGreenMask:     green_mask_q <= pwdata;
        RegBlueMask:      blue_mask_q  <= pwdata;
        default: ;
      endcase
    end
  end

  // Register read mux.
  always_comb begin
    unique case (cfg_idx)
      RegBytesPerPixel: prdata = {29'd0, bpp_q};
      RegMsbFirst:      prdata = {31'd0, msb_first_q};
      RegRedMask:       prdata = red_mask_q;
      RegGreenMask:     prdata = green_mask_q;
      RegBlueMask:      prdata = blue_mask_q;
      default:          prdata = 32'd0;
    endcase
  end

  // Channel masks and divisors, indexed red, green, blue.
  logic [31:0] mask_c [NumChan];
  div_t        dvs_c  [NumChan];

  always_comb begin
    mask_c[0] = red_mask_q;
    mask_c[1] = green_mask_q;
    mask_c[2] = blue_mask_q;
    for (int c = 0; c < NumChan; c++) begin
      dvs_c[c] = {mask_c[c], 1'b0};
    end
  end

  // Pipeline flow control: a stage loads when it is empty or its word moves on.
  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] ready_s;

  always_comb begin
    ready_s[LastStage] = !valid_q[LastStage] || rgb_o.ready;
    for (int k = LastStage - 1; k >= 0; k--) begin
      ready_s[k] = !valid_q[k] || ready_s[k+1];
    end
  end

  assign pix_i.ready = ready_s[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ready_s[0]) begin
        valid_q[0] <= pix_i.valid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (ready_s[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // Stage 0: assemble the pixel word from the clamped byte count and order.
  logic [1:0]  nm1;
  logic [31:0] word;
  logic [1:0]  src_byte;

  always_comb begin
    if (bpp_q == 3'd0) begin
      nm1 = 2'd0;
    end else if (bpp_q > 3'd4) begin
      nm1 = 2'd3;
    end else begin
      nm1 = 2'(bpp_q - 3'd1);
    end
    word = '0;
    for (int j = 0; j < 4; j++) begin
      src_byte = msb_first_q ? 2'(nm1 - 2'(j)) : 2'(j);
      if (2'(j) <= nm1) begin
        word[8*j +: 8] = pix_i.pixel_bytes[8*src_byte +: 8];
      end
    end
  end

  logic [31:0] val0_q [NumChan];
  num_t        num1_q [NumChan];
  num_t        rem2_q [NumChan];
  num_t        rem3_q [NumChan];
  num_t        rem4_q [NumChan];
  logic [1:0]  quo2_q [NumChan];
  logic [3:0]  quo3_q [NumChan];
  logic [5:0]  quo4_q [NumChan];
  logic [7:0]  out_q  [NumChan];

  // Division steps, two quotient bits per stage.
  div_res_t s2_hi [NumChan], s2_lo [NumChan];
  div_res_t s3_hi [NumChan], s3_lo [NumChan];
  div_res_t s4_hi [NumChan], s4_lo [NumChan];
  div_res_t s5_hi [NumChan], s5_lo [NumChan];

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      s2_hi[c] = div_step(num1_q[c], dvs_c[c], 3'd7);
      s2_lo[c] = div_step(s2_hi[c].rem, dvs_c[c], 3'd6);
      s3_hi[c] = div_step(rem2_q[c], dvs_c[c], 3'd5);
      s3_lo[c] = div_step(s3_hi[c].rem, dvs_c[c], 3'd4);
      s4_hi[c] = div_step(rem3_q[c], dvs_c[c], 3'd3);
      s4_lo[c] = div_step(s4_hi[c].rem, dvs_c[c], 3'd2);
      s5_hi[c] = div_step(rem4_q[c], dvs_c[c], 3'd1);
      s5_lo[c] = div_step(s5_hi[c].rem, dvs_c[c], 3'd0);
    end
  end

  // Datapath registers; each stage loads with its flow-control enable.
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NumChan; c++) begin
      if (ready_s[0]) begin
        val0_q[c] <= word & mask_c[c];
      end
      // Numerator v*510 + m, built from shifts.
      if (ready_s[1]) begin
        num1_q[c] <= (num_t'(val0_q[c]) << 9) - (num_t'(val0_q[c]) << 1)
                     + num_t'(mask_c[c]);
      end
      if (ready_s[2]) begin
        rem2_q[c] <= s2_lo[c].rem;
        quo2_q[c] <= {s2_hi[c].qbit, s2_lo[c].qbit};
      end
      if (ready_s[3]) begin
        rem3_q[c] <= s3_lo[c].rem;
        quo3_q[c] <= {quo2_q[c], s3_hi[c].qbit, s3_lo[c].qbit};
      end
      if (ready_s[4]) begin
        rem4_q[c] <= s4_lo[c].rem;
        quo4_q[c] <= {quo3_q[c], s4_hi[c].qbit, s4_lo[c].qbit};
      end
      // A zero mask gives a zero channel.
      if (ready_s[LastStage]) begin
        out_q[c] <= (mask_c[c] == 32'd0) ? 8'd0
                    : {quo4_q[c], s5_hi[c].qbit, s5_lo[c].qbit};
      end
    end
  end

  assign rgb_o.valid = valid_q[LastStage];
  assign rgb_o.red   = out_q[0];
  assign rgb_o.green = out_q[1];
  assign rgb_o.blue  = out_q[2];

`ifndef SYNTHESIS
  // The pipeline takes a word whenever the output side is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!valid_q[LastStage] || rgb_o.ready) |-> pix_i.ready)
    else $error("input stalled although the output can move");

  // Stage 1 only fills from a full stage 0.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_q[1]) |-> $past(valid_q[0]))
    else $error("stage 1 filled from an empty stage 0");

  // After bit 2 the partial remainder is below four divisors.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[4] && red_mask_q != 32'd0) |-> (rem4_q[0] < (num_t'(dvs_c[0]) << 2)))
    else $error("red divider remainder out of range");

  // A zero blue mask gives a zero blue channel on the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rgb_o.valid && blue_mask_q == 32'd0) |-> (rgb_o.blue == 8'd0))
    else $error("blue channel nonzero with a zero mask");
`endif

endmodule
